/* rtl/core/rrts_pkg.sv */
// Package for the round-robin task scheduler: sizes, codes and request types.
// Shared by rrts_slot_mem and round_robin_task_scheduler_top; depends on nothing.
package rrts_pkg;

    localparam int MAX_TASKS  = 4;
    localparam int ADDR_WIDTH = 16;
    localparam int SLOT_W     = $clog2(MAX_TASKS);
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);

    localparam int ENTRY_W    = 16;
    localparam int SLOT_OUT_W = 2;
    localparam int LIVE_W     = 3;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_CREATE = 2'd1,
        OP_YIELD  = 2'd2,
        OP_TERM   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        RES_DONE    = 2'd0,
        RES_FULL    = 2'd1,
        RES_PHASE   = 2'd2,
        RES_NOREADY = 2'd3
    } t_res_code;

    typedef enum logic [1:0] {
        ST_DEAD    = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2
    } t_slot_st;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_fsm;

    typedef struct packed {
        t_opcode              opcode;
        logic [ENTRY_W-1:0]   task_entry;
    } t_req;

    typedef struct packed {
        t_res_code             status;
        logic                  running_valid;
        logic [SLOT_OUT_W-1:0] running_slot;
        logic [ENTRY_W-1:0]    running_entry;
        logic [SLOT_OUT_W-1:0] created_slot;
        logic [LIVE_W-1:0]     live_tasks;
    } t_res;

    typedef struct packed {
        logic [SLOT_W-1:0]     rd_addr;
        logic                  st_we;
        logic [SLOT_W-1:0]     st_waddr;
        t_slot_st              st_wdata;
        logic                  en_we;
        logic [SLOT_W-1:0]     en_waddr;
        logic [ADDR_WIDTH-1:0] en_wdata;
    } t_mem_ctl;

endpackage

/* rtl/core/rrts_slot_mem.sv */
// Slot table: status memory and entry address memory, with a registered read.
// Status entries carry reset-cleared valid bits so unwritten slots read dead. Uses rrts_pkg.
module rrts_slot_mem
    import rrts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mem_ctl              i_ctl,
    output t_slot_st              o_rd_st,
    output logic [ADDR_WIDTH-1:0] o_rd_entry
);

    t_slot_st              r_st_mem [MAX_TASKS];
    logic [ADDR_WIDTH-1:0] r_en_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0]  r_vld;
    t_slot_st              r_rd_st;
    logic [ADDR_WIDTH-1:0] r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.st_we) begin
            r_vld[i_ctl.st_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.st_we) begin
            r_st_mem[i_ctl.st_waddr] <= i_ctl.st_wdata;
        end
        r_rd_st <= r_vld[i_ctl.rd_addr] ? r_st_mem[i_ctl.rd_addr] : ST_DEAD;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_we) begin
            r_en_mem[i_ctl.en_waddr] <= i_ctl.en_wdata;
        end
        r_rd_entry <= r_en_mem[i_ctl.rd_addr];
    end

    assign o_rd_st    = r_rd_st;
    assign o_rd_entry = r_rd_entry;

endmodule

/* rtl/core/round_robin_task_scheduler_top.sv */
// Round-robin task scheduler top: request FSM, slot scan and result register.
// Depends on rrts_pkg and rrts_slot_mem.
//
// Usage: requests enter on i_req / i_req_valid / o_req_ready, one result per
// request leaves on o_res / o_res_valid / i_res_ready; both are valid/ready.
// A request is taken only while the scheduler is idle. Start, create, yield
// and terminate that need a slot walk read the slot table one slot per cycle
// through its single read port, pipelined, in the scan state. A request
// rejected at once goes from idle straight to the finish state, where its
// result loads once the output register is free; one with a walk passes
// through the scan state first. The scheduler is ready for the next request
// in the same cycle that o_res_valid rises.
// Reset is synchronous: all slots read dead at once through per-slot valid
// bits, no clearing pass; not started, no task running, count zero.
// When the receiver stalls, the waiting result holds in the output register;
// one more request is taken and worked, then the block waits to load it.
module round_robin_task_scheduler_top
    import rrts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(MAX_TASKS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    t_fsm                  r_state, n_state;
    logic                  r_started, n_started;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [SLOT_W-1:0]     r_next, n_next;
    logic [SLOT_W-1:0]     r_cur, n_cur;
    logic                  r_cur_valid, n_cur_valid;
    logic [ADDR_WIDTH-1:0] r_cur_entry, n_cur_entry;
    logic [ADDR_WIDTH-1:0] r_new_entry, n_new_entry;
    t_res_code             r_status, n_status;
    logic [SLOT_W-1:0]     r_created, n_created;
    logic                  r_is_create, n_is_create;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]      r_left, n_left;
    logic                  r_pend, n_pend;
    logic [SLOT_W-1:0]     r_pend_idx, n_pend_idx;
    t_res                  r_res, n_res;
    logic                  r_res_valid, n_res_valid;

    t_mem_ctl              w_ctl;
    t_slot_st              w_rd_st;
    logic [ADDR_WIDTH-1:0] w_rd_entry;
    logic                  w_acc;
    logic                  w_scan_req;
    logic                  w_issue;
    logic                  w_hit;
    logic                  w_load;

    rrts_slot_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_rd_st    (w_rd_st),
        .o_rd_entry (w_rd_entry)
    );

    assign w_acc   = i_req_valid && o_req_ready;
    assign w_issue = (r_left != '0);
    assign w_hit   = r_pend && (r_is_create ? (w_rd_st == ST_DEAD) : (w_rd_st == ST_READY));
    assign w_load  = (r_state == S_FIN) && (!r_res_valid || i_res_ready);

    always_comb begin
        unique case (i_req.opcode)
            OP_START:        w_scan_req = !r_started && (r_count != '0);
            OP_CREATE:       w_scan_req = (r_count < CNT_W'(MAX_TASKS));
            OP_YIELD, OP_TERM: w_scan_req = r_started;
            default:         w_scan_req = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = w_scan_req ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (w_hit || !w_issue) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and table access
    always_comb begin
        o_req_ready    = (r_state == S_IDLE);
        o_res_valid    = r_res_valid;
        o_res          = r_res;
        w_ctl.rd_addr  = r_idx;
        w_ctl.st_we    = 1'b0;
        w_ctl.st_waddr = r_cur;
        w_ctl.st_wdata = ST_DEAD;
        w_ctl.en_we    = 1'b0;
        w_ctl.en_waddr = r_pend_idx;
        w_ctl.en_wdata = r_new_entry;
        if (w_acc && r_started && r_cur_valid
            && (i_req.opcode == OP_YIELD || i_req.opcode == OP_TERM)) begin
            w_ctl.st_we    = 1'b1;
            w_ctl.st_waddr = r_cur;
            w_ctl.st_wdata = (i_req.opcode == OP_YIELD) ? ST_READY : ST_DEAD;
        end else if (r_state == S_SCAN && w_hit) begin
            w_ctl.st_we    = 1'b1;
            w_ctl.st_waddr = r_pend_idx;
            w_ctl.st_wdata = r_is_create ? ST_READY : ST_RUNNING;
            w_ctl.en_we    = r_is_create;
        end
    end

    // datapath
    always_comb begin
        n_started   = r_started;
        n_count     = r_count;
        n_next      = r_next;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_cur_entry = r_cur_entry;
        n_new_entry = r_new_entry;
        n_status    = r_status;
        n_created   = r_created;
        n_is_create = r_is_create;
        n_idx       = r_idx;
        n_left      = r_left;
        n_pend      = 1'b0;
        n_pend_idx  = r_idx;
        n_res       = r_res;
        n_res_valid = r_res_valid;

        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_status    = RES_DONE;
                    n_created   = '0;
                    n_left      = CNT_W'(MAX_TASKS);
                    n_new_entry = ADDR_WIDTH'(i_req.task_entry);
                    n_is_create = 1'b0;
                    n_idx       = r_next;
                    unique case (i_req.opcode)
                        OP_START: begin
                            if (w_scan_req) begin
                                n_started = 1'b1;
                            end else begin
                                n_status = RES_PHASE;
                            end
                        end
                        OP_CREATE: begin
                            if (w_scan_req) begin
                                n_is_create = 1'b1;
                                n_idx       = '0;
                            end else begin
                                n_status = RES_FULL;
                            end
                        end
                        OP_YIELD, OP_TERM: begin
                            if (!r_started) begin
                                n_status = RES_PHASE;
                            end else begin
                                if (r_cur_valid && i_req.opcode == OP_TERM
                                    && r_count != '0) begin
                                    n_count = r_count - CNT_W'(1);
                                end
                                n_cur_valid = 1'b0;
                            end
                        end
                        default: n_status = RES_PHASE;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_idx  = slot_inc(r_idx);
                    n_left = r_left - CNT_W'(1);
                end
                n_pend     = w_issue;
                n_pend_idx = r_idx;
                if (w_hit) begin
                    if (r_is_create) begin
                        n_count   = r_count + CNT_W'(1);
                        n_created = r_pend_idx;
                    end else begin
                        n_cur       = r_pend_idx;
                        n_cur_valid = 1'b1;
                        n_next      = slot_inc(r_pend_idx);
                        n_cur_entry = w_rd_entry;
                    end
                end else if (!w_issue) begin
                    if (r_is_create) begin
                        n_status = RES_FULL;
                    end else begin
                        n_status    = RES_NOREADY;
                        n_cur_valid = 1'b0;
                        n_cur       = '0;
                    end
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_res_valid         = 1'b1;
                    n_res.status        = r_status;
                    n_res.running_valid = r_cur_valid;
                    n_res.running_slot  = r_cur_valid ? SLOT_OUT_W'(r_cur) : '0;
                    n_res.running_entry = r_cur_valid ? ENTRY_W'(r_cur_entry) : '0;
                    n_res.created_slot  = SLOT_OUT_W'(r_created);
                    n_res.live_tasks    = LIVE_W'(r_count);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_count     <= '0;
            r_next      <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_count     <= n_count;
            r_next      <= n_next;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_entry <= n_cur_entry;
        r_new_entry <= n_new_entry;
        r_status    <= n_status;
        r_created   <= n_created;
        r_is_create <= n_is_create;
        r_idx       <= n_idx;
        r_pend_idx  <= n_pend_idx;
        r_res       <= n_res;
    end

`ifndef NO_ASSERTIONS
    a_run_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> r_started)
        else $error("task running before start");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TASKS))
        else $error("live count beyond table size");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_left == '0) |=> (r_state == S_FIN))
        else $error("slot walk did not finish");

    a_acc_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state != S_IDLE))
        else $error("accepted request not worked");

    a_noready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == RES_NOREADY) |-> !o_res.running_valid)
        else $error("no-ready result reports a running task");
`endif

endmodule
